>>> sv/stvs_pkg.sv
package stvs_pkg;

    localparam int unsigned CfgCount      = 8;
    localparam int unsigned CfgIndexWidth = $clog2(CfgCount);
    localparam int unsigned CfgWidth      = 31;
    localparam int unsigned SpeedLimit    = 655;
    localparam int unsigned MulCycles     = 32;
    localparam int unsigned DivCycles     = 49;

    localparam logic [CfgIndexWidth-1:0] CFG_GAIN  = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_MASS  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_IZ    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_A     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_B     = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_CF    = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_CR    = 3'd6;
    localparam logic [CfgIndexWidth-1:0] CFG_DT    = 3'd7;

    localparam logic [CfgWidth-1:0] CFG_RESET [CfgCount] = '{
        31'd32768, 31'd65536, 31'd6554, 31'd7209,
        31'd7209, 31'd65536, 31'd65536, 31'd655
    };

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_LOAD,
        FS_MUL,
        FS_DIV,
        FS_WB,
        FS_DONE
    } fsm_t;

    typedef enum logic [3:0] {
        SP_VX,
        SP_TF,
        SP_AF,
        SP_TR,
        SP_AR,
        SP_FF,
        SP_FR,
        SP_MA,
        SP_MOM,
        SP_RDOT,
        SP_VXR,
        SP_VYDOT,
        SP_VYNEW,
        SP_RNEW
    } step_t;

endpackage

>>> sv/single_track_vehicle_step_unit.sv
// Operation: when the step runs, an item goes from input transfer to result
// through ten bit-serial multiplies and four bit-serial divides, each with a
// setup state (FS_LOAD) and a write-back state (FS_WB) around it, then a state
// to hand off the result (FS_DONE); at or below the speed limit only the first multiply runs.
// Items: a new item is taken only in FS_IDLE, once the last result has been handed off,
// which an output stall can hold; the shared shift-add/restoring unit sets the pace.
// Reset: asynchronous, active low; clears state, configuration to defaults.
module single_track_vehicle_step_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [stvs_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [stvs_pkg::CfgWidth-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [15:0]                  steering_angle,
    input  logic signed [15:0]                  pedal_position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  longitudinal_speed,
    output logic signed [31:0]                  lateral_speed,
    output logic signed [31:0]                  yaw_rate
);
    import stvs_pkg::*;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            r = v[31:0];
        end
        else if (v[33])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    fsm_t  state_reg, state_next;
    step_t step_reg, step_next;
    logic [CfgWidth-1:0] cfg_reg [CfgCount];

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] mx_reg, mx_next;
    logic [31:0] my_reg, my_next;
    logic [63:0] acc_reg, acc_next;
    logic [48:0] nq_reg, nq_next;
    logic [31:0] rem_reg, rem_next;
    logic        sign_reg, sign_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [15:0] steer_reg, steer_next;
    logic signed [15:0] pedal_reg, pedal_next;
    logic signed [31:0] vx_reg, vx_next;
    logic signed [31:0] vy_reg, vy_next;
    logic signed [31:0] r_reg, r_next;
    logic signed [31:0] t0_reg, t0_next;
    logic signed [31:0] t1_reg, t1_next;
    logic signed [31:0] ff_reg, ff_next;
    logic signed [31:0] fr_reg, fr_next;
    logic signed [31:0] lon_reg, lon_next;
    logic signed [31:0] lat_reg, lat_next;
    logic signed [31:0] yaw_reg, yaw_next;

    logic signed [32:0] op_x, op_y, c_val;
    logic               c_neg, p_neg, is_div, sh15;
    logic [32:0]        mag_x, mag_y;
    logic [31:0]        vabs;
    logic [31:0]        mass_div, iz_div;
    logic signed [31:0] fsum;
    logic [32:0]        add_hi;
    logic [32:0]        trial;
    logic               ge;
    logic [63:0]        rnd_full;
    logic [48:0]        mag_res;
    logic signed [31:0] p_res;
    logic signed [33:0] c_term, p_term;
    logic signed [31:0] res;
    logic               fast;

    assign vabs     = vx_reg[31] ? 32'(-vx_reg) : 32'(vx_reg);
    assign mass_div = (cfg_reg[CFG_MASS] == '0) ? 32'd1 : {1'b0, cfg_reg[CFG_MASS]};
    assign iz_div   = (cfg_reg[CFG_IZ] == '0) ? 32'd1 : {1'b0, cfg_reg[CFG_IZ]};
    assign fsum     = sat34(34'(ff_reg) + 34'(fr_reg));

    always_comb
    begin
        op_x   = '0;
        op_y   = '0;
        c_val  = '0;
        c_neg  = 1'b0;
        p_neg  = 1'b0;
        is_div = 1'b0;
        sh15   = 1'b0;
        unique case (step_reg)
            SP_VX:
            begin
                op_x = 33'(pedal_reg);
                op_y = {2'b00, cfg_reg[CFG_GAIN]};
                sh15 = 1'b1;
            end
            SP_TF:
            begin
                op_x  = {2'b00, cfg_reg[CFG_A]};
                op_y  = 33'(r_reg);
                c_val = 33'(vy_reg);
            end
            SP_AF:
            begin
                op_x   = 33'(t0_reg);
                op_y   = {1'b0, vabs};
                is_div = 1'b1;
                c_val  = 33'(signed'({steer_reg, 2'b00}));
                p_neg  = 1'b1;
            end
            SP_TR:
            begin
                op_x  = {2'b00, cfg_reg[CFG_B]};
                op_y  = 33'(r_reg);
                c_val = 33'(vy_reg);
                c_neg = 1'b1;
            end
            SP_AR:
            begin
                op_x   = 33'(t1_reg);
                op_y   = {1'b0, vabs};
                is_div = 1'b1;
            end
            SP_FF:
            begin
                op_x = {2'b00, cfg_reg[CFG_CF]};
                op_y = 33'(t0_reg);
            end
            SP_FR:
            begin
                op_x = {2'b00, cfg_reg[CFG_CR]};
                op_y = 33'(t1_reg);
            end
            SP_MA:
            begin
                op_x = {2'b00, cfg_reg[CFG_A]};
                op_y = 33'(ff_reg);
            end
            SP_MOM:
            begin
                op_x  = {2'b00, cfg_reg[CFG_B]};
                op_y  = 33'(fr_reg);
                c_val = 33'(t0_reg);
                p_neg = 1'b1;
            end
            SP_RDOT:
            begin
                op_x   = 33'(t0_reg);
                op_y   = {1'b0, iz_div};
                is_div = 1'b1;
            end
            SP_VXR:
            begin
                op_x = 33'(vx_reg);
                op_y = 33'(r_reg);
            end
            SP_VYDOT:
            begin
                op_x   = 33'(fsum);
                op_y   = {1'b0, mass_div};
                is_div = 1'b1;
                c_val  = 33'(t1_reg);
                c_neg  = 1'b1;
            end
            SP_VYNEW:
            begin
                op_x  = 33'(t1_reg);
                op_y  = {2'b00, cfg_reg[CFG_DT]};
                c_val = 33'(vy_reg);
            end
            SP_RNEW:
            begin
                op_x  = 33'(t0_reg);
                op_y  = {2'b00, cfg_reg[CFG_DT]};
                c_val = 33'(r_reg);
            end
            default:
            begin
                op_x = '0;
            end
        endcase
    end

    assign mag_x = op_x[32] ? 33'(-op_x) : 33'(op_x);
    assign mag_y = op_y[32] ? 33'(-op_y) : 33'(op_y);

    assign add_hi = {1'b0, acc_reg[63:32]} + (my_reg[0] ? {1'b0, mx_reg} : 33'd0);
    assign trial  = {rem_reg, nq_reg[48]};
    assign ge     = trial >= {1'b0, mx_reg};

    assign rnd_full = acc_reg + (sh15 ? 64'h4000 : 64'h8000);
    assign mag_res  = is_div ? nq_reg : (sh15 ? rnd_full[63:15] : {1'b0, rnd_full[63:16]});

    always_comb
    begin
        if (sign_reg)
        begin
            p_res = (mag_res > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(-mag_res[31:0]);
        end
        else
        begin
            p_res = (mag_res > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag_res[31:0]);
        end
    end

    assign c_term = c_neg ? -34'(c_val) : 34'(c_val);
    assign p_term = p_neg ? -34'(p_res) : 34'(p_res);
    assign res    = sat34(c_term + p_term);
    assign fast   = (res > 32'sd655) || (res < -32'sd655);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        acc_next       = acc_reg;
        nq_next        = nq_reg;
        rem_next       = rem_reg;
        sign_next      = sign_reg;
        steer_next     = steer_reg;
        pedal_next     = pedal_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        r_next         = r_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        ff_next        = ff_reg;
        fr_next        = fr_reg;
        lon_next       = lon_reg;
        lat_next       = lat_reg;
        yaw_next       = yaw_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (in_valid)
                begin
                    steer_next = steering_angle;
                    pedal_next = pedal_position;
                    step_next  = SP_VX;
                    state_next = FS_LOAD;
                end
            end
            FS_LOAD:
            begin
                cnt_next  = '0;
                acc_next  = '0;
                rem_next  = '0;
                sign_next = is_div ? op_x[32] : (op_x[32] ^ op_y[32]);
                if (is_div)
                begin
                    mx_next    = mag_y[31:0];
                    nq_next    = {1'b0, mag_x[31:0], 16'd0} + 49'(mag_y[31:1]);
                    state_next = FS_DIV;
                end
                else
                begin
                    mx_next    = mag_y[31:0];
                    my_next    = mag_x[31:0];
                    state_next = FS_MUL;
                end
            end
            FS_MUL:
            begin
                acc_next = {add_hi, acc_reg[31:1]};
                my_next  = {1'b0, my_reg[31:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MulCycles - 1))
                begin
                    state_next = FS_WB;
                end
            end
            FS_DIV:
            begin
                rem_next = ge ? 32'(trial - {1'b0, mx_reg}) : trial[31:0];
                nq_next  = {nq_reg[47:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DivCycles - 1))
                begin
                    state_next = FS_WB;
                end
            end
            FS_WB:
            begin
                state_next = FS_LOAD;
                step_next  = step_t'(step_reg + 4'd1);
                unique case (step_reg)
                    SP_VX:
                    begin
                        vx_next = res;
                        if (!fast)
                        begin
                            vy_next    = '0;
                            r_next     = '0;
                            state_next = FS_DONE;
                        end
                    end
                    SP_TF, SP_AF, SP_MA, SP_MOM, SP_RDOT:
                    begin
                        t0_next = res;
                    end
                    SP_TR, SP_AR, SP_VXR, SP_VYDOT:
                    begin
                        t1_next = res;
                    end
                    SP_FF:
                    begin
                        ff_next = res;
                    end
                    SP_FR:
                    begin
                        fr_next = res;
                    end
                    SP_VYNEW:
                    begin
                        vy_next = res;
                    end
                    SP_RNEW:
                    begin
                        r_next     = res;
                        state_next = FS_DONE;
                    end
                    default:
                    begin
                        state_next = FS_DONE;
                    end
                endcase
            end
            FS_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    lon_next       = vx_reg;
                    lat_next       = vy_reg;
                    yaw_next       = r_reg;
                    out_valid_next = 1'b1;
                    state_next     = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            step_reg      <= SP_VX;
            out_valid_reg <= 1'b0;
            vy_reg        <= '0;
            r_reg         <= '0;
            cnt_reg       <= '0;
            cfg_reg       <= CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            vy_reg        <= vy_next;
            r_reg         <= r_next;
            cnt_reg       <= cnt_next;
            if (cfg_write)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        acc_reg   <= acc_next;
        nq_reg    <= nq_next;
        rem_reg   <= rem_next;
        sign_reg  <= sign_next;
        steer_reg <= steer_next;
        pedal_reg <= pedal_next;
        vx_reg    <= vx_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        ff_reg    <= ff_next;
        fr_reg    <= fr_next;
        lon_reg   <= lon_next;
        lat_reg   <= lat_next;
        yaw_reg   <= yaw_next;
    end

    assign in_stall           = (state_reg != FS_IDLE);
    assign out_valid          = out_valid_reg;
    assign longitudinal_speed = lon_reg;
    assign lateral_speed      = lat_reg;
    assign yaw_rate           = yaw_reg;

    a_slow_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lateral_speed != 0 || yaw_rate != 0)
        |-> (longitudinal_speed > 32'sd655 || longitudinal_speed < -32'sd655))
        else $error("nonzero lateral state below speed limit");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FS_DIV |-> cnt_reg < 6'(DivCycles))
        else $error("divide count overrun");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FS_MUL |-> cnt_reg < 6'(MulCycles))
        else $error("multiply count overrun");

    a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == FS_DONE) |-> $past(step_reg) == SP_VX || $past(step_reg) == SP_RNEW)
        else $error("result before last step");

endmodule
